[src/blps_pkg.sv]
package blps_pkg;

  // Field widths
  localparam int unsigned SampleWidth = 8;
  localparam int unsigned LevelWidth  = 3;
  localparam int unsigned MvWidth     = 14;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 48;
  localparam int unsigned NumThr      = 6;
  localparam int unsigned IdleWidth   = 22;
  localparam int unsigned KeyWidth    = 6;
  localparam int unsigned BeepWidth   = 5;
  localparam int unsigned MinWidth    = 16;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [LevelWidth-1:0]  level_t;
  typedef logic [MvWidth-1:0]     mv_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LEVEL_THRESHOLDS    = 2'd0,
    CFG_POWEROFF_MINUTES    = 2'd1,
    CFG_AUTO_KEYLOCK_ENABLE = 2'd2,
    CFG_LOW_LEVEL_LIMIT     = 2'd3
  } cfg_idx_t;

  // Request codes
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_ACTIVITY = 1'b1;

  // Constants
  localparam sample_t             TopThreshold = 8'hBB;
  localparam logic [CfgDataWidth-1:0] ThrReset = 48'hA49E98928C86;
  localparam level_t              LowLimitReset = 3'd1;
  localparam logic [KeyWidth-1:0] KeylockSecs  = 6'd60;
  localparam logic [BeepWidth-1:0] BeepInterval = 5'd30;
  // sample*482/10 == floor(sample * (241 * 52429) / 2^18) for 8-bit samples
  localparam logic [31:0]         MvRecip      = 32'd12635389;
  localparam int unsigned         MvShift      = 18;

endpackage

[src/blps_req_if.sv]
interface blps_req_if import blps_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    cmd;
  sample_t battery_sample;
  logic    keypad_locked;

  modport source (output valid, output cmd, output battery_sample, output keypad_locked,
                  input ready);
  modport sink (input valid, input cmd, input battery_sample, input keypad_locked,
                output ready);
endinterface

[src/blps_rsp_if.sv]
interface blps_rsp_if import blps_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t battery_level;
  mv_t    battery_mv;
  logic   low_battery_alert;
  logic   beep_pulse;
  logic   shutdown_request;
  logic   keylock_request;

  modport source (output valid, output battery_level, output battery_mv,
                  output low_battery_alert, output beep_pulse, output shutdown_request,
                  output keylock_request, input ready);
  modport sink (input valid, input battery_level, input battery_mv,
                input low_battery_alert, input beep_pulse, input shutdown_request,
                input keylock_request, output ready);
endinterface

[src/battery_level_power_supervisor_unit.sv]
// Battery level and power supervisor. Each request is either a one-second
// tick carrying an 8-bit battery sample or a user-activity event. Every
// request yields exactly one response: the battery level (0..7, from six
// programmable thresholds plus a fixed top threshold of 0xBB), the voltage
// in millivolts, the low-battery alert, a warning beep every 30 low-battery
// ticks, an auto power-off request after the programmed idle minutes and a
// keypad lock request after 60 idle seconds. Activity clears both idle
// counters. Timing: a request is registered in the input stage, evaluated
// combinationally and lands in the response register, and one request is
// accepted every cycle; only a stalled response holds the pipeline.
// Write configuration only while no request is in flight.
module battery_level_power_supervisor_unit import blps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  blps_req_if.sink                req,
  blps_rsp_if.source              rsp
);

  // Configuration registers
  logic [CfgDataWidth-1:0] level_thresholds;
  logic [MinWidth-1:0]     poweroff_minutes;
  logic                    auto_keylock_enable;
  level_t                  low_level_limit;

  // Supervisor state
  logic [IdleWidth-1:0] idle_count, idle_count_next;
  logic [KeyWidth-1:0]  keylock_count, keylock_count_next;
  logic [BeepWidth-1:0] beep_count, beep_count_next;
  logic                 alert_flag, alert_flag_next;

  // Input stage
  logic    s1_valid;
  logic    s1_cmd;
  sample_t s1_sample;
  logic    s1_locked;

  // Response register
  logic   out_valid;
  level_t out_level;
  mv_t    out_mv;
  logic   out_alert, out_beep, out_shut, out_klock;

  logic advance, take, process;
  logic [IdleWidth-1:0] auto_off_limit;
  level_t level;
  logic [31:0] mv_prod;
  logic beep, shut, klock;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign take      = req.valid && req.ready;
  assign process   = s1_valid && advance;

  // minutes * 60 as shift and subtract
  assign auto_off_limit = {poweroff_minutes, 6'b0} - {4'b0, poweroff_minutes, 2'b0};

  // Level: index of the first threshold the sample is below
  always_comb begin
    level = level_t'(NumThr + 1);
    if (s1_sample < TopThreshold) level = level_t'(NumThr);
    for (int i = NumThr - 1; i >= 0; i--) begin
      if (s1_sample < level_thresholds[i*SampleWidth +: SampleWidth]) level = level_t'(i);
    end
  end

  // Millivolts by constant reciprocal
  assign mv_prod = 32'(s1_sample) * MvRecip;

  // Counter updates for the request in the input stage
  always_comb begin
    idle_count_next    = idle_count;
    keylock_count_next = keylock_count;
    beep_count_next    = beep_count;
    alert_flag_next    = alert_flag;
    beep  = 1'b0;
    shut  = 1'b0;
    klock = 1'b0;
    if (s1_cmd == CMD_ACTIVITY) begin
      idle_count_next    = '0;
      keylock_count_next = '0;
    end else begin
      if (poweroff_minutes != '0) begin
        if (idle_count < auto_off_limit) idle_count_next = idle_count + 1'b1;
        shut = (idle_count_next >= auto_off_limit);
      end
      if (auto_keylock_enable && !s1_locked) begin
        if (keylock_count < KeylockSecs) keylock_count_next = keylock_count + 1'b1;
        klock = (keylock_count_next >= KeylockSecs);
      end
      if (level <= low_level_limit) begin
        alert_flag_next = 1'b1;
        if (beep_count + 1'b1 >= BeepInterval) begin
          beep_count_next = '0;
          beep = 1'b1;
        end else begin
          beep_count_next = beep_count + 1'b1;
        end
      end else begin
        alert_flag_next = 1'b0;
        beep_count_next = '0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_thresholds    <= ThrReset;
      poweroff_minutes    <= '0;
      auto_keylock_enable <= 1'b0;
      low_level_limit     <= LowLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEVEL_THRESHOLDS:    level_thresholds    <= cfg_data;
        CFG_POWEROFF_MINUTES:    poweroff_minutes    <= cfg_data[MinWidth-1:0];
        CFG_AUTO_KEYLOCK_ENABLE: auto_keylock_enable <= cfg_data[0];
        CFG_LOW_LEVEL_LIMIT:     low_level_limit     <= cfg_data[LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count    <= '0;
      keylock_count <= '0;
      beep_count    <= '0;
      alert_flag    <= 1'b0;
    end else begin
      if (process) begin
        keylock_count <= keylock_count_next;
        beep_count    <= beep_count_next;
        alert_flag    <= alert_flag_next;
      end
      if (cfg_write && cfg_idx_t'(cfg_index) == CFG_POWEROFF_MINUTES) begin
        idle_count <= '0;
      end else if (process) begin
        idle_count <= idle_count_next;
      end
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd    <= req.cmd;
      s1_sample <= req.battery_sample;
      s1_locked <= req.keypad_locked;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_level <= level;
      out_mv    <= mv_prod[MvShift +: MvWidth];
      out_alert <= alert_flag_next;
      out_beep  <= beep;
      out_shut  <= shut;
      out_klock <= klock;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.battery_level     = out_level;
  assign rsp.battery_mv        = out_mv;
  assign rsp.low_battery_alert = out_alert;
  assign rsp.beep_pulse        = out_beep;
  assign rsp.shutdown_request  = out_shut;
  assign rsp.keylock_request   = out_klock;

`ifndef NO_ASSERTIONS
  // Beep counter wraps before reaching the interval
  a_beep_range: assert property (@(posedge clk) disable iff (rst)
    beep_count < BeepInterval) else $error("beep_count out of range");

  // Keylock counter saturates at its limit
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    keylock_count <= KeylockSecs) else $error("keylock_count past limit");

  // Idle counter never passes the auto-off limit
  a_idle_range: assert property (@(posedge clk) disable iff (rst)
    idle_count <= auto_off_limit) else $error("idle_count past limit");

  // A beep only comes with the alert
  a_beep_alert: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.beep_pulse |-> rsp.low_battery_alert)
    else $error("beep without alert");

  // Activity responses carry no requests
  a_activity: assert property (@(posedge clk) disable iff (rst)
    process && s1_cmd == CMD_ACTIVITY |=>
      rsp.valid && !rsp.beep_pulse && !rsp.shutdown_request && !rsp.keylock_request)
    else $error("activity response flags set");
`endif

endmodule

[bench/blps_status_check.sv]
`timescale 1ns / 1ps

module blps_status_check import blps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  blps_req_if                     req,
  blps_rsp_if                     rsp,
  output int unsigned             mismatch_count,
  output int unsigned             outstanding
);

  localparam int unsigned MvMul      = 482;
  localparam int unsigned MvDiv      = 10;
  localparam int unsigned SecsPerMin = 60;

  typedef struct packed {
    level_t level;
    mv_t    mv;
    logic   alert;
    logic   beep;
    logic   shutdown;
    logic   keylock;
  } status_t;

  // Shadow copies of the registers
  logic [CfgDataWidth-1:0] thresholds;
  logic [MinWidth-1:0]     off_minutes;
  logic                    autolock_en;
  level_t                  low_limit;

  // Supervisor counters
  logic [IdleWidth-1:0] idle_secs;
  logic [KeyWidth-1:0]  lock_secs;
  logic [BeepWidth-1:0] beep_secs;
  logic                 alert_on;

  // Statuses owed by the block, oldest first
  status_t status_due[$];

  // First threshold, in list order, that the sample falls below
  function automatic level_t level_of(sample_t s);
    for (int i = 0; i < NumThr; i++) begin
      if (s < thresholds[8*i +: 8]) return level_t'(i);
    end
    return (s < TopThreshold) ? level_t'(NumThr) : level_t'(NumThr + 1);
  endfunction

  // Advance the counters by one request and build the status it yields
  task automatic advance_supervisor(input logic c, input sample_t s, input logic locked,
                                    output status_t st);
    int unsigned idle_limit;
    st          = '0;
    st.level    = level_of(s);
    st.mv       = mv_t'((32'(s) * MvMul) / MvDiv);
    if (c == CMD_ACTIVITY) begin
      idle_secs = '0;
      lock_secs = '0;
    end else begin
      if (off_minutes != '0) begin
        idle_limit = off_minutes * SecsPerMin;
        if (idle_secs < idle_limit) idle_secs = idle_secs + 1'b1;
        st.shutdown = (idle_secs >= idle_limit);
      end
      if (autolock_en && !locked) begin
        if (lock_secs < KeylockSecs) lock_secs = lock_secs + 1'b1;
        st.keylock = (lock_secs >= KeylockSecs);
      end
      // low battery: beep once every interval of consecutive low ticks
      if (st.level <= low_limit) begin
        alert_on  = 1'b1;
        beep_secs = beep_secs + 1'b1;
        if (beep_secs >= BeepInterval) begin
          beep_secs = '0;
          st.beep   = 1'b1;
        end
      end else begin
        alert_on  = 1'b0;
        beep_secs = '0;
      end
    end
    st.alert = alert_on;
  endtask

  task automatic check_field(input string name, input logic [MvWidth-1:0] want,
                             input logic [MvWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t fresh;
    status_t oldest;
    if (rst) begin
      thresholds     = ThrReset;
      off_minutes    = '0;
      autolock_en    = 1'b0;
      low_limit      = LowLimitReset;
      idle_secs      = '0;
      lock_secs      = '0;
      beep_secs      = '0;
      alert_on       = 1'b0;
      mismatch_count = 0;
      status_due.delete();
    end else begin
      // register writes; a new auto-off limit restarts the idle count
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEVEL_THRESHOLDS: thresholds = cfg_data;
          CFG_POWEROFF_MINUTES: begin
            off_minutes = cfg_data[MinWidth-1:0];
            idle_secs   = '0;
          end
          CFG_AUTO_KEYLOCK_ENABLE: autolock_en = cfg_data[0];
          CFG_LOW_LEVEL_LIMIT: low_limit = cfg_data[LevelWidth-1:0];
          default: ;
        endcase
      end
      // accepted request
      if (req.valid && req.ready) begin
        advance_supervisor(req.cmd, req.battery_sample, req.keypad_locked, fresh);
        status_due.push_back(fresh);
      end
      // accepted response
      if (rsp.valid && rsp.ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: response with nothing expected, level %0d mv %0d", $time,
                   rsp.battery_level, rsp.battery_mv);
          mismatch_count++;
        end else begin
          oldest = status_due.pop_front();
          check_field("battery_level", MvWidth'(oldest.level), MvWidth'(rsp.battery_level));
          check_field("battery_mv", oldest.mv, rsp.battery_mv);
          check_field("low_battery_alert", MvWidth'(oldest.alert),
                      MvWidth'(rsp.low_battery_alert));
          check_field("beep_pulse", MvWidth'(oldest.beep), MvWidth'(rsp.beep_pulse));
          check_field("shutdown_request", MvWidth'(oldest.shutdown),
                      MvWidth'(rsp.shutdown_request));
          check_field("keylock_request", MvWidth'(oldest.keylock),
                      MvWidth'(rsp.keylock_request));
        end
      end
    end
    outstanding <= status_due.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import blps_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned DrainCycles = 4;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PULSED,
    READY_COIN
  } ready_mode_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_write;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned requests_sent = 0;
  int unsigned activity_sent = 0;
  ready_mode_t ready_mode    = READY_ALWAYS;
  int unsigned ready_hold    = 0;
  int unsigned ready_step    = 0;

  blps_req_if req ();
  blps_rsp_if rsp ();

  battery_level_power_supervisor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  blps_status_check status_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req            (req),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #2 clk = ~clk;

  // hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // response back-pressure: a random mode is picked each time the last one's hold runs out
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = $urandom_range(16, 96);
    end
    ready_hold--;
    ready_step++;
    case (ready_mode)
      READY_ALWAYS: rsp.ready <= 1'b1;
      READY_MOSTLY: rsp.ready <= ($urandom_range(0, 3) != 0);
      READY_PULSED: rsp.ready <= (ready_step % 5 == 0);
      default:      rsp.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // one request; bursts of random length separated by random gaps
  task automatic send_request(input logic c, input sample_t s, input logic locked);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    req.valid          <= 1'b1;
    req.cmd            <= c;
    req.battery_sample <= s;
    req.keypad_locked  <= locked;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    burst_left--;
    requests_sent++;
    if (c == CMD_ACTIVITY) activity_sent++;
  endtask

  // stop sending and let every owed response come back
  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  initial begin
    logic [CfgDataWidth-1:0] thr_set;
    logic [MinWidth-1:0]     min_set;
    logic                    lock_set;
    level_t                  low_set;
    int unsigned             left, seq_len, lo, hi, center, roll, step, thr_val;

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = CFG_LEVEL_THRESHOLDS;
    cfg_data           = '0;
    req.valid          = 1'b0;
    req.cmd            = CMD_TICK;
    req.battery_sample = '0;
    req.keypad_locked  = 1'b0;
    rsp.ready          = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset register values, both sides of thresholds 0x86, 0x8C, 0x92, 0xA4 and 0xBB, extremes
    send_request(CMD_TICK, 8'h00, 1'b0);
    send_request(CMD_TICK, 8'hFF, 1'b0);
    send_request(CMD_TICK, 8'h85, 1'b1);
    send_request(CMD_TICK, 8'h86, 1'b0);
    send_request(CMD_TICK, 8'h8B, 1'b0);
    send_request(CMD_TICK, 8'h8C, 1'b1);
    send_request(CMD_TICK, 8'h91, 1'b0);
    send_request(CMD_TICK, 8'h92, 1'b0);
    send_request(CMD_TICK, 8'h98, 1'b0);
    send_request(CMD_TICK, 8'h9E, 1'b0);
    send_request(CMD_TICK, 8'hA3, 1'b0);
    send_request(CMD_TICK, 8'hA4, 1'b0);
    send_request(CMD_TICK, 8'hBA, 1'b0);
    send_request(CMD_TICK, 8'hBB, 1'b0);
    send_request(CMD_ACTIVITY, 8'hFF, 1'b1);
    send_request(CMD_ACTIVITY, 8'h00, 1'b0);
    send_request(CMD_TICK, 8'h7F, 1'b1);
    send_request(CMD_TICK, 8'h80, 1'b0);
    send_request(CMD_TICK, 8'h55, 1'b0);
    send_request(CMD_TICK, 8'hAA, 1'b1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          // every level counts as low; one-minute auto-off, keylock on
          thr_set  = ThrReset;
          min_set  = 16'd1;
          lock_set = 1'b1;
          low_set  = 3'd7;
        end
        1: begin
          // all thresholds zero, everything disabled
          thr_set  = '0;
          min_set  = '0;
          lock_set = 1'b0;
          low_set  = 3'd0;
        end
        2: begin
          // all thresholds at maximum, longest auto-off
          thr_set  = '1;
          min_set  = '1;
          lock_set = 1'b1;
          low_set  = 3'd3;
        end
        default: begin
          // random thresholds, ascending or in any order
          thr_val = $urandom_range(0, 120);
          for (int i = 0; i < NumThr; i++) begin
            if (ph % 2 == 1) begin
              step    = $urandom_range(0, 40);
              thr_val = (thr_val + step > 255) ? 255 : thr_val + step;
            end else begin
              thr_val = $urandom_range(0, 255);
            end
            thr_set[8*i +: 8] = thr_val[7:0];
          end
          min_set  = ($urandom_range(0, 4) == 0) ? 16'd0 : MinWidth'($urandom_range(1, 2));
          lock_set = 1'($urandom_range(0, 1));
          low_set  = level_t'($urandom_range(0, 7));
        end
      endcase

      drain();
      write_reg(CFG_LEVEL_THRESHOLDS, thr_set);
      write_reg(CFG_POWEROFF_MINUTES, CfgDataWidth'(min_set));
      write_reg(CFG_AUTO_KEYLOCK_ENABLE, CfgDataWidth'(lock_set));
      write_reg(CFG_LOW_LEVEL_LIMIT, CfgDataWidth'(low_set));
      cfg_write <= 1'b0;

      // runs of ticks over the full range or around one battery level, broken by the odd activity
      left = PhaseItems;
      while (left > 0) begin
        seq_len = $urandom_range(10, 120);
        if ($urandom_range(0, 1) == 0) begin
          lo = 0;
          hi = 255;
        end else begin
          center = $urandom_range(0, 255);
          lo     = (center < 6) ? 0 : center - 6;
          hi     = (center > 249) ? 255 : center + 6;
        end
        for (int j = 0; j < seq_len && left > 0; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 2) begin
            send_request(CMD_ACTIVITY, sample_t'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
          end else begin
            send_request(CMD_TICK, sample_t'($urandom_range(lo, hi)), roll < 8);
          end
          left--;
        end
      end
    end

    drain();
    $display("Run covered %0d requests (%0d activity) under reset values and %0d settings",
             requests_sent, activity_sent, NumPhases);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
